// File: rtl/iasc_pkg.sv
package iasc_pkg;

  localparam int unsigned NUM_W          = 31;
  localparam int unsigned RADIX_W        = 6;
  localparam int unsigned REM_W          = 5;
  localparam int unsigned CHR_W          = 7;
  localparam int unsigned MAX_DIGITS_DEF = 32;
  localparam int unsigned QUEUE_DEPTH    = 2;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd16;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd32;

  localparam logic [CHR_W-1:0] CHR_ZERO   = 7'h30;  // '0'
  localparam logic [CHR_W-1:0] CHR_ALPHA  = 7'h41;  // 'A'
  localparam logic [CHR_W-1:0] CHR_ERROR  = 7'h00;
  localparam logic [REM_W-1:0] DEC_LIMIT  = 5'd10;

  // One queued conversion job.
  typedef struct packed {
    logic [NUM_W-1:0]   number;
    logic [RADIX_W-1:0] radix;
    logic               bad;
  } job_t;

  // Divider result.
  typedef struct packed {
    logic [NUM_W-1:0] quotient;
    logic [REM_W-1:0] remainder;
  } div_res_t;

  function automatic logic [CHR_W-1:0] to_ascii(input logic [REM_W-1:0] v);
    logic [CHR_W-1:0] r;
    if (v < DEC_LIMIT) begin
      r = CHR_ZERO + CHR_W'(v);
    end else begin
      r = CHR_ALPHA + CHR_W'(v - DEC_LIMIT);
    end
    return r;
  endfunction

endpackage

// File: rtl/iasc_front.sv
module iasc_front
  import iasc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [RADIX_W-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [NUM_W-1:0]   in_number_i,
  output logic               job_valid_o,
  input  logic               job_pop_i,
  output job_t               job_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [RADIX_W-1:0] radix_q;
  job_t               queue_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               push, pop;
  job_t               new_job;

  assign in_ready_o  = (cnt_q != CNT_W'(QUEUE_DEPTH));
  assign job_valid_o = (cnt_q != '0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = job_pop_i && job_valid_o;
  assign job_o       = queue_q[rd_ptr_q];

  // Classify on entry: radix is captured with the number.
  always_comb begin
    new_job.number = in_number_i;
    new_job.radix  = radix_q;
    new_job.bad    = (radix_q < RADIX_MIN) || (radix_q > RADIX_MAX);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q  <= RADIX_RESET;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        radix_q <= cfg_wdata_i;
      end
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= new_job;
    end
  end

endmodule

// File: rtl/iasc_div.sv
module iasc_div
  import iasc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [NUM_W-1:0]   dividend_i,
  input  logic [RADIX_W-1:0] divisor_i,
  output logic               done_o,
  output div_res_t           res_o
);

  localparam int unsigned STEP_W = $clog2(NUM_W);

  logic               busy_q, done_q;
  logic [STEP_W-1:0]  step_q;
  logic [NUM_W-1:0]   quo_q;
  logic [REM_W-1:0]   rem_q;
  logic [RADIX_W-1:0] div_q;
  logic [RADIX_W-1:0] trial;
  logic               fits;

  // Restoring division, one quotient bit per cycle.
  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign fits  = (trial >= div_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      div_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(NUM_W - 1);
        quo_q  <= dividend_i;
        rem_q  <= '0;
        div_q  <= divisor_i;
      end else if (busy_q) begin
        quo_q <= {quo_q[NUM_W-2:0], fits};
        rem_q <= fits ? REM_W'(trial - div_q) : REM_W'(trial);
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q - 1'b1;
        end
      end
    end
  end

  assign done_o          = done_q;
  assign res_o.quotient  = quo_q;
  assign res_o.remainder = rem_q;

endmodule

// File: rtl/iasc_back.sv
module iasc_back
  import iasc_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_valid_i,
  output logic             job_pop_o,
  input  job_t             job_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [CHR_W-1:0] out_char_o,
  output logic             out_last_o,
  output logic             out_bad_o
);

  localparam int unsigned IDX_W = $clog2(MAX_DIGITS);
  localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_EMIT,
    ST_ERR
  } state_e;

  state_e             state_q;
  logic [CNT_W-1:0]   n_q, n_next;
  logic [IDX_W-1:0]   rd_idx_q;
  logic [RADIX_W-1:0] base_q;
  logic               start_q;
  logic [NUM_W-1:0]   dividend_q;
  logic               out_valid_q, out_last_q, out_bad_q;
  logic [CHR_W-1:0]   out_char_q;
  logic [CHR_W-1:0]   store_q [MAX_DIGITS];
  logic [CHR_W-1:0]   rd_data_q;
  logic               div_done;
  div_res_t           div_res;
  logic               wr_en;
  logic               out_free;
  logic               out_load;

  iasc_div u_div (
    .clk_i,
    .rst_ni,
    .start_i    (start_q),
    .dividend_i (dividend_q),
    .divisor_i  (base_q),
    .done_o     (div_done),
    .res_o      (div_res)
  );

  assign out_free  = !out_valid_q || out_ready_i;
  // Output register gets a new transaction this cycle.
  assign out_load  = out_free && ((state_q == ST_EMIT) || (state_q == ST_ERR));
  assign job_pop_o = (state_q == ST_IDLE) && job_valid_i;
  // Digits beyond the store depth are dropped (most significant end).
  assign wr_en     = (state_q == ST_DIV) && div_done && (n_q < CNT_W'(MAX_DIGITS));
  assign n_next    = wr_en ? n_q + 1'b1 : n_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[n_q[IDX_W-1:0]] <= to_ascii(div_res.remainder);
    end
    rd_data_q <= store_q[rd_idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      n_q         <= '0;
      rd_idx_q    <= '0;
      base_q      <= '0;
      start_q     <= 1'b0;
      dividend_q  <= '0;
      out_valid_q <= 1'b0;
      out_char_q  <= '0;
      out_last_q  <= 1'b0;
      out_bad_q   <= 1'b0;
    end else begin
      start_q <= 1'b0;
      if (out_valid_q && out_ready_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            if (job_i.bad) begin
              state_q <= ST_ERR;
            end else begin
              base_q     <= job_i.radix;
              dividend_q <= job_i.number;
              start_q    <= 1'b1;
              n_q        <= '0;
              state_q    <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          // Always at least one pass, so zero gives a single '0'.
          if (div_done) begin
            n_q <= n_next;
            if (div_res.quotient == '0) begin
              rd_idx_q <= IDX_W'(n_next - 1'b1);
              state_q  <= ST_READ;
            end else begin
              dividend_q <= div_res.quotient;
              start_q    <= 1'b1;
            end
          end
        end
        ST_READ: begin
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_char_q  <= rd_data_q;
            out_last_q  <= (rd_idx_q == '0);
            out_bad_q   <= 1'b0;
            if (rd_idx_q == '0) begin
              state_q <= ST_IDLE;
            end else begin
              rd_idx_q <= rd_idx_q - 1'b1;
              state_q  <= ST_READ;
            end
          end
        end
        ST_ERR: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_char_q  <= CHR_ERROR;
            out_last_q  <= 1'b1;
            out_bad_q   <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;
  assign out_bad_o   = out_bad_q;

endmodule

// File: rtl/integer_to_radix_ascii.sv
// Integer to ASCII digit string in a programmable base (2..32).
// Input stream: one transaction per number (s_axis_tdata[30:0]).
// Output stream: one transaction per digit, most significant first; tlast marks
// the least significant digit. A base outside 2..32 gives one transaction with
// character 0, tlast = 1 and tuser = 1 instead of digits.
// cfg_we_i/cfg_wdata_i write the base; write it only while the block is idle.
// The base is sampled when a number is accepted.
// Each digit costs one pass of the shared bit-serial divider, after which it is
// written to the digit store; the digits are then read back from the store
// and loaded into the output register one by one. One number is converted at
// a time: the next is taken from the queue only after the last digit of the
// previous one is loaded.
// A 2-entry queue sits between the input side and the converter, so up to two
// numbers are taken while a conversion is running.
// Reset: base returns to 16, queue and output register are emptied.
// A stalled receiver holds the output register; emission of the next digit waits
// until the register frees up, but the next number starts once the last is loaded.
module integer_to_radix_ascii
  import iasc_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration
  input  logic               cfg_we_i,
  input  logic [RADIX_W-1:0] cfg_wdata_i,   // radix
  // Input stream
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [31:0]        s_axis_tdata,  // [30:0] number, [31] zero
  // Output stream
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [7:0]         m_axis_tdata,  // [6:0] digit_char, [7] zero
  output logic               m_axis_tlast,  // last_digit
  output logic               m_axis_tuser   // bad_radix
);

  logic             job_valid, job_pop;
  job_t             job;
  logic [CHR_W-1:0] out_char;

  // Front: base register, classification, job queue.
  iasc_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_number_i (s_axis_tdata[NUM_W-1:0]),
    .job_valid_o (job_valid),
    .job_pop_i   (job_pop),
    .job_o       (job)
  );

  // Back: repeated division, digit store, digit emission.
  iasc_back #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .job_valid_i (job_valid),
    .job_pop_o   (job_pop),
    .job_i       (job),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_char_o  (out_char),
    .out_last_o  (m_axis_tlast),
    .out_bad_o   (m_axis_tuser)
  );

  assign m_axis_tdata = {1'b0, out_char};

endmodule

// File: verif/tb_integer_to_radix_ascii.sv
`timescale 1ns / 1ps

module tb_integer_to_radix_ascii;
  import iasc_pkg::*;

  // One digit transaction on the output stream.
  typedef struct packed {
    logic [CHR_W-1:0] ch;
    logic             last_digit;
    logic             bad_radix;
  } digit_res_t;

  localparam longint unsigned NUM_MASK = (64'd1 << NUM_W) - 1;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [RADIX_W-1:0] cfg_wdata_i;     // radix
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [31:0]        s_axis_tdata;    // [30:0] number, [31] zero
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [7:0]         m_axis_tdata;    // [6:0] digit_char, [7] zero
  logic               m_axis_tlast;    // last_digit
  logic               m_axis_tuser;    // bad_radix

  // Digits still owed by the block, oldest first.
  digit_res_t         digits_due[$];
  // Shadow of the radix register, updated on every write.
  logic [RADIX_W-1:0] radix_shadow = RADIX_RESET;
  int unsigned        errors = 0;

  // Traffic shaping knobs, written by the test tasks.
  int unsigned        src_idle_pct = 0;
  int unsigned        sink_stall_pct = 0;
  int unsigned        hold_len = 0;
  int unsigned        hold_seq = 0;
  int unsigned        hold_taken = 0;
  int unsigned        hold_left = 0;

  integer_to_radix_ascii u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #4 clk_i = ~clk_i;

  // Safety net: far beyond the slowest legal run (all base-2 numbers, 31 digits
  // each, plus stalls and the long hold).
  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  // Expected digit string for one accepted number, in the current radix.
  // Remainders are collected least significant first, then pushed out MSD first.
  function automatic void spell_number(input logic [NUM_W-1:0] value);
    logic [CHR_W-1:0] glyphs[$];
    logic [NUM_W-1:0] quot;
    logic [NUM_W-1:0] rem;
    digit_res_t       d;
    if (radix_shadow < RADIX_MIN || radix_shadow > RADIX_MAX) begin
      // Base out of range: one error transaction, nothing else.
      d.ch         = CHR_ERROR;
      d.last_digit = 1'b1;
      d.bad_radix  = 1'b1;
      digits_due.push_back(d);
      return;
    end
    quot = value;
    // do-while so that zero still yields a single '0'
    do begin
      rem  = quot % radix_shadow;
      quot = quot / radix_shadow;
      if (rem < DEC_LIMIT) begin
        glyphs.push_front(CHR_ZERO + CHR_W'(rem));
      end else begin
        glyphs.push_front(CHR_ALPHA + CHR_W'(rem - DEC_LIMIT));
      end
    end while (quot != 0);
    foreach (glyphs[i]) begin
      d.ch         = glyphs[i];
      d.last_digit = (i == glyphs.size() - 1);
      d.bad_radix  = 1'b0;
      digits_due.push_back(d);
    end
  endfunction

  // Input monitor: every accepted number is turned into expected digits.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      spell_number(s_axis_tdata[NUM_W-1:0]);
    end
  end

  // Output checker: each digit transaction against the oldest expectation.
  always @(posedge clk_i) begin
    digit_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (digits_due.size() == 0) begin
        errors++;
        $display("%0t unexpected digit: got data=%h last=%b user=%b", $time,
                 m_axis_tdata, m_axis_tlast, m_axis_tuser);
      end else begin
        want = digits_due.pop_front();
        if (m_axis_tdata !== {1'b0, want.ch} || m_axis_tlast !== want.last_digit ||
            m_axis_tuser !== want.bad_radix) begin
          errors++;
          $display("%0t digit mismatch: expected data=%h last=%b user=%b,",
                   $time, {1'b0, want.ch}, want.last_digit, want.bad_radix,
                   " got data=%h last=%b user=%b",
                   m_axis_tdata, m_axis_tlast, m_axis_tuser);
        end
      end
    end
  end

  // Receiver: random back-pressure, plus a long hold-off counted here whenever
  // a test bumps hold_seq.
  always @(posedge clk_i) begin
    if (hold_seq != hold_taken) begin
      hold_taken = hold_seq;
      hold_left  = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Offer one number and wait for its transaction. tvalid stays high on return
  // so back-to-back numbers need no gap.
  task automatic send_number(input logic [NUM_W-1:0] value);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= {1'b0, NUM_W'($urandom)};  // junk while idle
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, value};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Drop tvalid and wait until every owed digit has come out.
  task automatic park_and_drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (digits_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Only called with the block idle.
  task automatic write_radix(input logic [RADIX_W-1:0] r);
    cfg_wdata_i <= r;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    radix_shadow = r;
    @(posedge clk_i);
  endtask

  // Random number, biased toward short strings and radix-power boundaries.
  function automatic logic [NUM_W-1:0] pick_number();
    longint unsigned pw;
    int unsigned     k;
    int unsigned     kind;
    logic [NUM_W-1:0] n;
    kind = $urandom_range(9);
    pw   = 1;
    if (kind < 4) begin
      n = NUM_W'($urandom);
    end else if (kind < 6) begin
      n = NUM_W'($urandom_range(0, 40));
    end else if (kind < 8 && radix_shadow >= RADIX_MIN && radix_shadow <= RADIX_MAX) begin
      // r^k or r^k - 1: digit count rolls over right here
      k = $urandom_range(1, 30);
      while (k > 0 && pw * radix_shadow <= NUM_MASK) begin
        pw = pw * radix_shadow;
        k--;
      end
      n = NUM_W'(pw - $urandom_range(0, 1));
    end else begin
      n = {NUM_W{1'b1}} ^ (NUM_W'(1) << $urandom_range(0, NUM_W - 1));
    end
    return n;
  endfunction

  // Mostly legal bases, now and then an illegal one.
  function automatic logic [RADIX_W-1:0] pick_radix();
    if ($urandom_range(99) < 80) begin
      return RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX));
    end
    return RADIX_W'($urandom_range(0, 63));
  endfunction

  // Default base 16 straight out of reset, field extremes and bit patterns.
  task automatic test_reset_radix();
    send_number('0);
    send_number(NUM_W'(1));
    send_number({NUM_W{1'b1}});
    send_number(NUM_W'(32'h5555_5555));
    send_number(NUM_W'(32'h2AAA_AAAA));
    send_number(NUM_W'(15));
    send_number(NUM_W'(16));
    send_number(NUM_W'(255));
    park_and_drain();
  endtask

  // Smallest and largest legal base, plus decimal across the 9/10 digit-count boundary.
  task automatic test_radix_extremes();
    write_radix(RADIX_MIN);
    send_number({NUM_W{1'b1}});   // 31 digits, the longest string
    send_number('0);
    send_number(NUM_W'(1));
    park_and_drain();
    write_radix(RADIX_MAX);
    send_number({NUM_W{1'b1}});
    send_number(NUM_W'(31));      // top digit character
    send_number(NUM_W'(32));
    park_and_drain();
    write_radix(RADIX_W'(10));
    send_number(NUM_W'(1234567890));
    send_number(NUM_W'(9));
    send_number(NUM_W'(10));
    park_and_drain();
  endtask

  // Illegal bases on both sides of the range: one error transaction each.
  task automatic test_bad_radix();
    write_radix(RADIX_W'(0));
    send_number(pick_number());
    park_and_drain();
    write_radix(RADIX_W'(1));
    send_number('0);
    park_and_drain();
    write_radix(RADIX_W'(RADIX_MAX + 1));
    send_number({NUM_W{1'b1}});
    park_and_drain();
    write_radix({RADIX_W{1'b1}});
    send_number(pick_number());
    park_and_drain();
  endtask

  // Receiver holds off long while the sender keeps pushing: queue fills,
  // s_axis_tready drops, then everything must drain in order.
  task automatic test_long_hold();
    write_radix(RADIX_W'(16));
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_len       = 800;
    hold_seq++;
    repeat (8) send_number(NUM_W'($urandom_range(0, 4095)));
    park_and_drain();
  endtask

  // Random numbers under one idling mix, two bases per mix.
  task automatic test_random_mix(input int unsigned idle_pct, input int unsigned stall_pct);
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    repeat (2) begin
      write_radix(pick_radix());
      repeat (9) send_number(pick_number());
      park_and_drain();
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_reset_radix();
    test_radix_extremes();
    test_bad_radix();
    test_long_hold();
    test_random_mix(0, 0);
    test_random_mix(77, 0);
    test_random_mix(0, 77);
    test_random_mix(26, 26);

    // park_and_drain already waited for the last digit; give stray output a chance
    repeat (200) @(posedge clk_i);
    if (errors == 0 && digits_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
